[hw/rtl/apeg_pkg.sv]
// Shared types, widths, register codes and reset values for the power envelope gate.
package apeg_pkg;

  localparam int WINDOW_LEN_DEF   = 64;
  localparam int SAMPLE_SHIFT_DEF = 8;

  localparam int SAMPLE_W     = 32;
  localparam int ATTACK_W     = 16;
  localparam int DECAY_W      = 16;
  localparam int COUNT_W      = 6;
  localparam int LEVEL_STEP_W = 20;
  localparam int LEVEL_W      = 21;
  localparam int STATE_W      = 2;
  localparam int PSUM_W       = 32;
  localparam int ENV_W        = 31;
  localparam int SLOPE_W      = 32;
  localparam int CFG_IDX_W    = 3;
  localparam int CFG_DATA_W   = 20;
  localparam int OUT_TDATA_W  = 56;

  localparam logic [ATTACK_W-1:0]     ATTACK_RST  = 16'd20;
  localparam logic [DECAY_W-1:0]      DECAY_RST   = 16'd300;
  localparam logic [COUNT_W-1:0]      ENTER_RST   = 6'd16;
  localparam logic [COUNT_W-1:0]      HOLD_RST    = 6'd32;
  localparam logic [COUNT_W-1:0]      RELEASE_RST = 6'd16;
  localparam logic [LEVEL_STEP_W-1:0] LEVEL_RST   = 20'd180000;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ATTACK  = 3'd0,
    REG_DECAY   = 3'd1,
    REG_ENTER   = 3'd2,
    REG_HOLD    = 3'd3,
    REG_RELEASE = 3'd4,
    REG_LEVEL   = 3'd5
  } cfg_reg_t;

  typedef enum logic [STATE_W-1:0] {
    PH_WAIT   = 2'd0,
    PH_SIGNAL = 2'd1,
    PH_NOSIG  = 2'd2
  } phase_t;

  typedef struct packed {
    logic [ATTACK_W-1:0]     attack_step;
    logic [DECAY_W-1:0]      decay_limit;
    logic [COUNT_W-1:0]      enter_count;
    logic [COUNT_W-1:0]      hold_count;
    logic [COUNT_W-1:0]      release_count;
    logic [LEVEL_STEP_W-1:0] level_step;
  } cfg_t;

  // Width of the running sum of squares; wraps at 64 bits when it would grow past.
  function automatic int pow_w(input int win, input int shift);
    int sum;
    sum = 2 * (SAMPLE_W - shift) - 1 + $clog2(win);
    return (sum > 64) ? 64 : sum;
  endfunction

endpackage

[hw/rtl/audio_power_envelope_gate.sv]
// Top level: stream ports, configuration registers, power pipeline and envelope stage.
//
//  port group     | dir | fields (lsb first)
//  s_axis_*       | in  | tdata: sample[31:0]
//  m_axis_*       | out | tdata: level[20:0], detect_state[22:21], power_sum[54:23], pad
//  cfg_*          | in  | index 0..5, data in low bits
//
// One sample is taken every cycle unless the output stalls; the valid flag is registered
// once in each stage listed below, and m_axis_tvalid is the last of those registers.
// Stages: ring read, squares, window sum, envelope/detector into the output register.
// A stalled output register freezes the whole pipeline and drops s_axis_tready.
// Reset clears the ring's valid bits; unwritten entries read as zero.
module audio_power_envelope_gate #(
  parameter int WINDOW_LEN   = apeg_pkg::WINDOW_LEN_DEF,
  parameter int SAMPLE_SHIFT = apeg_pkg::SAMPLE_SHIFT_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  input  logic [apeg_pkg::SAMPLE_W-1:0]    s_axis_tdata,  // sample
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  output logic [apeg_pkg::OUT_TDATA_W-1:0] m_axis_tdata,  // level, detect_state, power_sum
  input  logic                             cfg_wr_en,
  input  logic [apeg_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [apeg_pkg::CFG_DATA_W-1:0]  cfg_data
);

  localparam int POW_W = apeg_pkg::pow_w(WINDOW_LEN, SAMPLE_SHIFT);

  apeg_pkg::cfg_t                  cfg;
  logic                            adv;
  logic                            p_vld;
  logic [POW_W-1:0]                power;
  logic [apeg_pkg::LEVEL_W-1:0]    out_level;
  logic [apeg_pkg::STATE_W-1:0]    out_state;
  logic [apeg_pkg::PSUM_W-1:0]     out_psum;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.attack_step   <= apeg_pkg::ATTACK_RST;
      cfg.decay_limit   <= apeg_pkg::DECAY_RST;
      cfg.enter_count   <= apeg_pkg::ENTER_RST;
      cfg.hold_count    <= apeg_pkg::HOLD_RST;
      cfg.release_count <= apeg_pkg::RELEASE_RST;
      cfg.level_step    <= apeg_pkg::LEVEL_RST;
    end else if (cfg_wr_en) begin
      case (apeg_pkg::cfg_reg_t'(cfg_index))
        apeg_pkg::REG_ATTACK:  cfg.attack_step   <= cfg_data[apeg_pkg::ATTACK_W-1:0];
        apeg_pkg::REG_DECAY:   cfg.decay_limit   <= cfg_data[apeg_pkg::DECAY_W-1:0];
        apeg_pkg::REG_ENTER:   cfg.enter_count   <= cfg_data[apeg_pkg::COUNT_W-1:0];
        apeg_pkg::REG_HOLD:    cfg.hold_count    <= cfg_data[apeg_pkg::COUNT_W-1:0];
        apeg_pkg::REG_RELEASE: cfg.release_count <= cfg_data[apeg_pkg::COUNT_W-1:0];
        apeg_pkg::REG_LEVEL:   cfg.level_step    <= cfg_data[apeg_pkg::LEVEL_STEP_W-1:0];
        default: begin
        end
      endcase
    end
  end

  assign s_axis_tready = adv;

  apeg_power #(
    .WINDOW_LEN  (WINDOW_LEN),
    .SAMPLE_SHIFT(SAMPLE_SHIFT)
  ) u_power (
    .clk   (clk),
    .rst   (rst),
    .adv   (adv),
    .in_vld(s_axis_tvalid),
    .sample(s_axis_tdata),
    .p_vld (p_vld),
    .power (power)
  );

  apeg_env #(
    .POW_W(POW_W)
  ) u_env (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .p_vld    (p_vld),
    .power    (power),
    .m_ready  (m_axis_tready),
    .adv      (adv),
    .out_vld  (m_axis_tvalid),
    .out_level(out_level),
    .out_state(out_state),
    .out_psum (out_psum)
  );

  assign m_axis_tdata = {1'b0, out_psum, out_state, out_level};

endmodule

[hw/rtl/apeg_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module apeg_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[hw/rtl/apeg_power.sv]
// Sample ring, exact squares and running window sum of squares (three stages).
module apeg_power #(
  parameter int WINDOW_LEN   = apeg_pkg::WINDOW_LEN_DEF,
  parameter int SAMPLE_SHIFT = apeg_pkg::SAMPLE_SHIFT_DEF
) (
  input  logic                                              clk,
  input  logic                                              rst,
  input  logic                                              adv,
  input  logic                                              in_vld,
  input  logic [apeg_pkg::SAMPLE_W-1:0]                     sample,
  output logic                                              p_vld,
  output logic [apeg_pkg::pow_w(WINDOW_LEN, SAMPLE_SHIFT)-1:0] power
);

  localparam int SW    = apeg_pkg::SAMPLE_W - SAMPLE_SHIFT;
  localparam int PTR_W = $clog2(WINDOW_LEN);
  localparam int SQ_W  = 2 * SW - 1;
  localparam int POW_W = apeg_pkg::pow_w(WINDOW_LEN, SAMPLE_SHIFT);

  logic                accept;
  logic [PTR_W-1:0]    ptr;
  logic [WINDOW_LEN-1:0] filled;
  logic signed [apeg_pkg::SAMPLE_W-1:0] shifted;
  logic [SW-1:0]       rdata;

  logic                s1_vld;
  logic [SW-1:0]       s1_val;
  logic [PTR_W-1:0]    s1_idx;
  logic                s1_old_ok;

  logic [SW-1:0]       old_val;
  logic [SW-1:0]       old_mag;
  logic [SW-1:0]       new_mag;

  logic                s2_vld;
  logic [SQ_W-1:0]     sq_old;
  logic [SQ_W-1:0]     sq_new;

  logic [POW_W-1:0]    running_power;
  logic [POW_W-1:0]    running_power_next;

  assign accept  = in_vld && adv;
  assign shifted = $signed(sample) >>> SAMPLE_SHIFT;

  apeg_ram #(
    .WIDTH(SW),
    .DEPTH(WINDOW_LEN)
  ) u_ring (
    .clk  (clk),
    .we   (adv && s1_vld),
    .waddr(s1_idx),
    .wdata(s1_val),
    .re   (accept),
    .raddr(ptr),
    .rdata(rdata)
  );

  // stage 1: old entry is back from the ring; never-written entries read as zero
  assign old_val  = s1_old_ok ? rdata : '0;
  assign old_mag  = old_val[SW-1] ? (~old_val + SW'(1)) : old_val;
  assign new_mag  = s1_val[SW-1] ? (~s1_val + SW'(1)) : s1_val;

  // stage 2: modular update of the window sum
  assign running_power_next = running_power - POW_W'(sq_old) + POW_W'(sq_new);

  always_ff @(posedge clk) begin
    if (rst) begin
      ptr           <= '0;
      filled        <= '0;
      s1_vld        <= 1'b0;
      s2_vld        <= 1'b0;
      p_vld         <= 1'b0;
      running_power <= '0;
    end else begin
      if (accept) begin
        ptr <= (ptr == PTR_W'(WINDOW_LEN - 1)) ? '0 : ptr + PTR_W'(1);
      end
      if (adv) begin
        s1_vld <= accept;
        s2_vld <= s1_vld;
        p_vld  <= s2_vld;
        if (s1_vld) begin
          filled[s1_idx] <= 1'b1;
        end
        if (s2_vld) begin
          running_power <= running_power_next;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_val    <= shifted[SW-1:0];
      s1_idx    <= ptr;
      s1_old_ok <= filled[ptr];
    end
    if (adv && s1_vld) begin
      sq_old <= SQ_W'(old_mag * old_mag);
      sq_new <= SQ_W'(new_mag * new_mag);
    end
  end

  assign power = running_power;

endmodule

[hw/rtl/apeg_env.sv]
// Envelope tracker, three-state detector and output register with stall handling.
module apeg_env #(
  parameter int POW_W = apeg_pkg::pow_w(apeg_pkg::WINDOW_LEN_DEF, apeg_pkg::SAMPLE_SHIFT_DEF)
) (
  input  logic                              clk,
  input  logic                              rst,
  input  apeg_pkg::cfg_t                    cfg,
  input  logic                              p_vld,
  input  logic [POW_W-1:0]                  power,
  input  logic                              m_ready,
  output logic                              adv,
  output logic                              out_vld,
  output logic [apeg_pkg::LEVEL_W-1:0]      out_level,
  output logic [apeg_pkg::STATE_W-1:0]      out_state,
  output logic [apeg_pkg::PSUM_W-1:0]       out_psum
);

  logic [apeg_pkg::ENV_W-1:0]          envelope;
  logic signed [apeg_pkg::SLOPE_W-1:0] slope;
  logic [apeg_pkg::PSUM_W-1:0]         peak;
  apeg_pkg::phase_t                    phase;
  logic [apeg_pkg::COUNT_W-1:0]        count;

  logic [apeg_pkg::ENV_W-1:0]          envelope_next;
  logic signed [apeg_pkg::SLOPE_W-1:0] slope_next;
  logic signed [apeg_pkg::SLOPE_W-1:0] slope_mid;
  apeg_pkg::phase_t                    phase_next;
  logic [apeg_pkg::COUNT_W-1:0]        count_next;
  logic [apeg_pkg::LEVEL_W-1:0]        level_next;

  logic                above;
  logic [31:0]         peak_sat;
  logic [32:0]         peak_3q;
  logic [31:0]         peak_half;
  logic [14:0]         decay_ceil;
  logic signed [32:0]  slope_ext;
  logic signed [32:0]  sum_att;
  logic signed [32:0]  sum_dec;
  logic signed [32:0]  neg_d;
  logic signed [32:0]  neg_q;
  logic signed [32:0]  env_sum;

  function automatic logic [31:0] sat32(input logic signed [32:0] x);
    if (x[32] != x[31]) begin
      return x[32] ? 32'h8000_0000 : 32'h7FFF_FFFF;
    end
    return x[31:0];
  endfunction

  assign adv = !out_vld || m_ready;

  assign above     = power > POW_W'(envelope);
  assign peak_sat  = (power > POW_W'(32'hFFFF_FFFF)) ? 32'hFFFF_FFFF : power[31:0];
  assign peak_half = {1'b0, peak[31:1]};
  assign peak_3q   = {1'b0, peak_half} + {3'b0, peak[31:2]};
  assign decay_ceil = 15'((17'(cfg.decay_limit) + 17'd3) >> 2);

  assign slope_ext = {slope[31], slope};
  assign sum_att   = slope_ext + $signed({17'b0, cfg.attack_step});
  assign sum_dec   = slope_ext - $signed({19'b0, cfg.decay_limit[15:2]});
  assign neg_d     = -$signed({17'b0, cfg.decay_limit});
  assign neg_q     = -$signed({18'b0, decay_ceil});

  always_comb begin
    if (above) begin
      slope_mid = sat32(sum_att);
    end else if ({2'b0, envelope} > peak_3q) begin
      // near the peak: keep ramping the decay until it reaches the floor
      if (slope_ext > neg_d) begin
        slope_mid = sat32(sum_dec);
      end else begin
        slope_mid = neg_d[31:0];
      end
    end else if ({1'b0, envelope} > peak_half) begin
      slope_mid = neg_q[31:0];
    end else begin
      slope_mid = -32'sd1;
    end
  end

  assign env_sum = $signed({2'b0, envelope}) + $signed({slope_mid[31], slope_mid});

  always_comb begin
    if (env_sum[32]) begin
      envelope_next = '0;
      slope_next    = '0;
    end else if (env_sum[31]) begin
      envelope_next = '1;
      slope_next    = slope_mid;
    end else begin
      envelope_next = env_sum[30:0];
      slope_next    = slope_mid;
    end
  end

  // detector next state
  always_comb begin
    phase_next = phase;
    count_next = count;
    case (phase)
      apeg_pkg::PH_WAIT: begin
        if (above) begin
          if (count == cfg.enter_count) begin
            phase_next = apeg_pkg::PH_SIGNAL;
            count_next = '0;
          end else begin
            count_next = count + apeg_pkg::COUNT_W'(1);
          end
        end else begin
          count_next = '0;
        end
      end
      apeg_pkg::PH_SIGNAL: begin
        if (count == cfg.hold_count) begin
          phase_next = apeg_pkg::PH_NOSIG;
          count_next = '0;
        end else begin
          count_next = count + apeg_pkg::COUNT_W'(1);
        end
      end
      apeg_pkg::PH_NOSIG: begin
        if (!above) begin
          if (count == cfg.release_count) begin
            phase_next = apeg_pkg::PH_WAIT;
            count_next = '0;
          end else begin
            count_next = count + apeg_pkg::COUNT_W'(1);
          end
        end
      end
      default: begin
      end
    endcase
  end

  // detector outputs
  always_comb begin
    case (phase_next)
      apeg_pkg::PH_SIGNAL: level_next = apeg_pkg::LEVEL_W'(cfg.level_step);
      apeg_pkg::PH_NOSIG:  level_next = {cfg.level_step, 1'b0};
      default:             level_next = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      envelope <= '0;
      slope    <= '0;
      peak     <= '0;
      phase    <= apeg_pkg::PH_WAIT;
      count    <= '0;
      out_vld  <= 1'b0;
    end else if (adv) begin
      out_vld <= p_vld;
      if (p_vld) begin
        envelope <= envelope_next;
        slope    <= slope_next;
        phase    <= phase_next;
        count    <= count_next;
        if (above) begin
          peak <= peak_sat;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv && p_vld) begin
      out_level <= level_next;
      out_state <= phase_next;
      out_psum  <= peak_sat;
    end
  end

  a_state_matches: assert property (@(posedge clk) disable iff (rst)
    out_vld |-> (out_state == phase))
    else $error("output state differs from detector state");

  a_wait_exit: assert property (@(posedge clk) disable iff (rst)
    (!$past(rst) && $past(phase) == apeg_pkg::PH_WAIT && phase != apeg_pkg::PH_WAIT)
      |-> (phase == apeg_pkg::PH_SIGNAL))
    else $error("wait state left for a state other than signal");

  a_count_clear: assert property (@(posedge clk) disable iff (rst)
    (!$past(rst) && phase != $past(phase)) |-> (count == '0))
    else $error("detector count not cleared on state change");

endmodule

[dv/audio_power_envelope_gate_tb.sv]
// Self-checking testbench for audio_power_envelope_gate: streamed samples, predicted results.
module audio_power_envelope_gate_tb;

  typedef logic [apeg_pkg::CFG_DATA_W-1:0] cfg_word_t;
  typedef logic [apeg_pkg::SAMPLE_W-1:0]   sample_word_t;
  typedef logic [apeg_pkg::LEVEL_W-1:0]    level_word_t;

  localparam logic [apeg_pkg::CFG_IDX_W-1:0] CFG_IDX_SPARE_A = 3'd6;
  localparam logic [apeg_pkg::CFG_IDX_W-1:0] CFG_IDX_SPARE_B = 3'd7;
  localparam int ST_LSB = apeg_pkg::LEVEL_W;
  localparam int PS_LSB = apeg_pkg::LEVEL_W + apeg_pkg::STATE_W;
  localparam int COUNT_MASK = (1 << apeg_pkg::COUNT_W) - 1;
  localparam longint PSUM_MAX  = 64'sd4294967295;
  localparam longint SLOPE_MAX = 64'sd2147483647;
  localparam longint SLOPE_MIN = -64'sd2147483648;
  localparam longint ENV_MAX   = 64'sd2147483647;
  localparam int LOUD_RUN = 300;

  typedef struct {
    logic [apeg_pkg::LEVEL_W-1:0] level;
    apeg_pkg::phase_t             state;
    logic [apeg_pkg::PSUM_W-1:0]  power;
  } gate_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [apeg_pkg::SAMPLE_W-1:0] s_axis_tdata = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [apeg_pkg::OUT_TDATA_W-1:0] m_axis_tdata;
  logic cfg_wr_en = 1'b0;
  logic [apeg_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [apeg_pkg::CFG_DATA_W-1:0] cfg_data = '0;

  audio_power_envelope_gate u_top (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always #4 clk = ~clk;

  // predictor state
  longint win_ring [apeg_pkg::WINDOW_LEN_DEF];
  int     win_ptr = 0;
  longint win_power = 0;
  longint env_level = 0;
  longint env_slope = 0;
  longint peak_power = 0;
  apeg_pkg::phase_t gate_phase = apeg_pkg::PH_WAIT;
  int     phase_cnt = 0;
  longint attack_cfg = apeg_pkg::ATTACK_RST;
  longint decay_cfg = apeg_pkg::DECAY_RST;
  int     enter_cfg = apeg_pkg::ENTER_RST;
  int     hold_cfg = apeg_pkg::HOLD_RST;
  int     release_cfg = apeg_pkg::RELEASE_RST;
  longint level_cfg = apeg_pkg::LEVEL_RST;

  logic [apeg_pkg::SAMPLE_W-1:0] pending_samples[$];
  gate_result_t                  gate_expected[$];
  int items_queued = 0;
  int results_seen = 0;
  int gate_errors = 0;
  bit idle_off = 1'b0;

  int send_gap = 0;
  int send_calm = 0;
  int rdy_gap = 0;
  int rdy_calm = 0;
  gate_result_t exp_r;

  initial begin
    for (int i = 0; i < apeg_pkg::WINDOW_LEN_DEF; i++) win_ring[i] = 0;
  end

  function automatic longint clamp_slope(input longint s);
    if (s > SLOPE_MAX) return SLOPE_MAX;
    if (s < SLOPE_MIN) return SLOPE_MIN;
    return s;
  endfunction

  // mostly no gap or short gaps, a few long ones, and occasional stretches with none
  function automatic int pick_gap(inout int calm_left);
    int r;
    if (idle_off) return 0;
    if (calm_left > 0) begin
      calm_left--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 4) begin
      calm_left = $urandom_range(20, 80);
      return 0;
    end
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(4, 40);
  endfunction

  task automatic predict_gate(input logic [apeg_pkg::SAMPLE_W-1:0] smp);
    logic signed [apeg_pkg::SAMPLE_W-1:0] shifted;
    longint nv;
    longint ov;
    longint pow_sat;
    longint nxt;
    bit above;
    gate_result_t r;
    shifted = $signed(smp) >>> apeg_pkg::SAMPLE_SHIFT_DEF;
    nv = shifted;
    ov = win_ring[win_ptr];
    win_power = win_power - ov * ov + nv * nv;
    win_ring[win_ptr] = nv;
    win_ptr = (win_ptr + 1) % apeg_pkg::WINDOW_LEN_DEF;
    pow_sat = (win_power > PSUM_MAX) ? PSUM_MAX : win_power;

    above = win_power > env_level;
    if (above) begin
      env_slope = clamp_slope(env_slope + attack_cfg);
      peak_power = pow_sat;
    end else if (env_level > (peak_power >> 1) + (peak_power >> 2)) begin
      if (env_slope > -decay_cfg) env_slope = clamp_slope(env_slope - (decay_cfg >> 2));
      else env_slope = -decay_cfg;
    end else if (env_level > (peak_power >> 1)) begin
      env_slope = -((decay_cfg + 3) >> 2);
    end else begin
      env_slope = -1;
    end

    nxt = env_level + env_slope;
    if (nxt < 0) begin
      env_level = 0;
      env_slope = 0;
    end else if (nxt > ENV_MAX) begin
      env_level = ENV_MAX;
    end else begin
      env_level = nxt;
    end

    case (gate_phase)
      apeg_pkg::PH_WAIT: begin
        if (above) begin
          if (phase_cnt == enter_cfg) begin
            gate_phase = apeg_pkg::PH_SIGNAL;
            phase_cnt = 0;
          end else begin
            phase_cnt = (phase_cnt + 1) & COUNT_MASK;
          end
        end else begin
          phase_cnt = 0;
        end
      end
      apeg_pkg::PH_SIGNAL: begin
        if (phase_cnt == hold_cfg) begin
          gate_phase = apeg_pkg::PH_NOSIG;
          phase_cnt = 0;
        end else begin
          phase_cnt = (phase_cnt + 1) & COUNT_MASK;
        end
      end
      apeg_pkg::PH_NOSIG: begin
        if (!above) begin
          if (phase_cnt == release_cfg) begin
            gate_phase = apeg_pkg::PH_WAIT;
            phase_cnt = 0;
          end else begin
            phase_cnt = (phase_cnt + 1) & COUNT_MASK;
          end
        end
      end
      default: ;
    endcase

    r.level = level_word_t'(longint'(gate_phase) * level_cfg);
    r.state = gate_phase;
    r.power = pow_sat[apeg_pkg::PSUM_W-1:0];
    gate_expected.push_back(r);
  endtask

  // sample driver
  always @(posedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
      send_gap = 0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) predict_gate(s_axis_tdata);
      if (!s_axis_tvalid || s_axis_tready) begin
        if (send_gap > 0) begin
          send_gap--;
          s_axis_tvalid <= 1'b0;
        end else if (pending_samples.size() > 0) begin
          s_axis_tdata <= pending_samples.pop_front();
          s_axis_tvalid <= 1'b1;
          send_gap = pick_gap(send_calm);
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // result monitor
  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
      rdy_gap = 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        results_seen++;
        if (gate_expected.size() == 0) begin
          $display("%0t: result with no transaction pending, expected none, actual %h",
                   $time, m_axis_tdata);
          gate_errors++;
        end else begin
          exp_r = gate_expected.pop_front();
          if (m_axis_tdata[0 +: apeg_pkg::LEVEL_W] !== exp_r.level) begin
            $display("%0t: level mismatch, expected %0d, actual %0d",
                     $time, exp_r.level, m_axis_tdata[0 +: apeg_pkg::LEVEL_W]);
            gate_errors++;
          end
          if (m_axis_tdata[ST_LSB +: apeg_pkg::STATE_W] !== exp_r.state) begin
            $display("%0t: detect_state mismatch, expected %0d, actual %0d",
                     $time, exp_r.state, m_axis_tdata[ST_LSB +: apeg_pkg::STATE_W]);
            gate_errors++;
          end
          if (m_axis_tdata[PS_LSB +: apeg_pkg::PSUM_W] !== exp_r.power) begin
            $display("%0t: power_sum mismatch, expected %0d, actual %0d",
                     $time, exp_r.power, m_axis_tdata[PS_LSB +: apeg_pkg::PSUM_W]);
            gate_errors++;
          end
        end
      end
      if (rdy_gap > 0) begin
        rdy_gap--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
        rdy_gap = pick_gap(rdy_calm);
      end
    end
  end

  task automatic push_sample(input logic [apeg_pkg::SAMPLE_W-1:0] s);
    pending_samples.push_back(s);
    items_queued++;
  endtask

  // random sample below 2**bits in magnitude, random sign; bits=32 gives any pattern
  function automatic logic [apeg_pkg::SAMPLE_W-1:0] rand_sample(input int bits);
    longint mag;
    if (bits >= 32) return $urandom;
    mag = longint'($urandom) & ((64'sd1 << bits) - 1);
    return $urandom_range(0, 1) ? sample_word_t'(-mag) : sample_word_t'(mag);
  endfunction

  task automatic wait_drained();
    while (results_seen < items_queued) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(input logic [apeg_pkg::CFG_IDX_W-1:0] idx,
                           input logic [apeg_pkg::CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    case (idx)
      apeg_pkg::REG_ATTACK:  attack_cfg = val[apeg_pkg::ATTACK_W-1:0];
      apeg_pkg::REG_DECAY:   decay_cfg = val[apeg_pkg::DECAY_W-1:0];
      apeg_pkg::REG_ENTER:   enter_cfg = val[apeg_pkg::COUNT_W-1:0];
      apeg_pkg::REG_HOLD:    hold_cfg = val[apeg_pkg::COUNT_W-1:0];
      apeg_pkg::REG_RELEASE: release_cfg = val[apeg_pkg::COUNT_W-1:0];
      apeg_pkg::REG_LEVEL:   level_cfg = val[apeg_pkg::LEVEL_STEP_W-1:0];
      default: ;
    endcase
  endtask

  task automatic end_writes();
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  task automatic write_all(input cfg_word_t atk, input cfg_word_t dcy, input cfg_word_t ent,
                           input cfg_word_t hld, input cfg_word_t rel, input cfg_word_t lvl);
    write_reg(apeg_pkg::REG_ATTACK, atk);
    write_reg(apeg_pkg::REG_DECAY, dcy);
    write_reg(apeg_pkg::REG_ENTER, ent);
    write_reg(apeg_pkg::REG_HOLD, hld);
    write_reg(apeg_pkg::REG_RELEASE, rel);
    write_reg(apeg_pkg::REG_LEVEL, lvl);
    end_writes();
  endtask

  // bursts of random samples of bounded magnitude, near silence and full-range noise
  task automatic queue_program(input int n);
    int done;
    int len;
    int kind;
    int bits;
    done = 0;
    while (done < n) begin
      kind = $urandom_range(0, 99);
      len = $urandom_range(5, 60);
      if (len > n - done) len = n - done;
      bits = (kind < 65) ? $urandom_range(9, 31) : (kind < 85) ? $urandom_range(0, 8) : 32;
      for (int i = 0; i < len; i++) push_sample(rand_sample(bits));
      done += len;
    end
  endtask

  initial begin
    #8000000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // field extremes and shift boundaries under reset settings
    push_sample(32'h0000_0000);
    push_sample(32'h0000_0001);
    push_sample(32'hFFFF_FFFF);
    push_sample(32'h0000_00FF);
    push_sample(32'h0000_0100);
    push_sample(32'hFFFF_FF00);
    push_sample(32'hFFFF_FEFF);
    push_sample(32'h7FFF_FFFF);
    push_sample(32'h8000_0000);
    push_sample(32'h7FFF_FFFF);
    push_sample(32'h8000_0000);
    push_sample(32'h00FF_FFFF);
    push_sample(32'hFF00_0000);
    push_sample(32'h5555_5555);
    push_sample(32'hAAAA_AAAA);
    push_sample(32'h1234_5678);
    for (int i = 0; i < 6; i++) push_sample(32'h0000_0000);
    wait_drained();

    for (int ph = 0; ph < 10; ph++) begin
      case (ph)
        0: write_all('0, '0, '0, '0, '0, '0);
        1: write_all(20'hFFFFF, 20'hFFFFF, 20'hFFFFF, 20'hFFFFF, 20'hFFFFF, 20'hFFFFF);
        2: write_all(cfg_word_t'(apeg_pkg::ATTACK_RST), cfg_word_t'(apeg_pkg::DECAY_RST),
                     cfg_word_t'(apeg_pkg::ENTER_RST), cfg_word_t'(apeg_pkg::HOLD_RST),
                     cfg_word_t'(apeg_pkg::RELEASE_RST), cfg_word_t'(apeg_pkg::LEVEL_RST));
        default: write_all(cfg_word_t'($urandom_range(0, 1) ? $urandom_range(1, 200) : $urandom),
                           cfg_word_t'($urandom), cfg_word_t'($urandom_range(0, 20)),
                           cfg_word_t'($urandom), cfg_word_t'($urandom_range(0, 20)),
                           cfg_word_t'($urandom));
      endcase
      if (ph % 3 == 1) begin
        // unmapped indexes must leave every register alone
        write_reg(CFG_IDX_SPARE_A, cfg_word_t'($urandom));
        write_reg(CFG_IDX_SPARE_B, cfg_word_t'($urandom));
        end_writes();
      end
      queue_program(70);
      wait_drained();
    end

    // sustained full-scale input until the envelope saturates, then silence
    write_all(20'hFFFFF, cfg_word_t'(apeg_pkg::DECAY_RST), cfg_word_t'(apeg_pkg::ENTER_RST),
              cfg_word_t'(apeg_pkg::HOLD_RST), cfg_word_t'(apeg_pkg::RELEASE_RST),
              cfg_word_t'(apeg_pkg::LEVEL_RST));
    idle_off = 1'b1;
    for (int i = 0; i < LOUD_RUN; i++)
      push_sample({$urandom_range(0, 1) ? 2'b10 : 2'b01, 30'($urandom)});
    for (int i = 0; i < 80; i++) push_sample(32'h0000_0000);
    wait_drained();

    if (gate_expected.size() != 0) begin
      $display("%0t: results missing, expected %0d more, actual 0",
               $time, gate_expected.size());
      gate_errors++;
    end
    if (gate_errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
